@@ rtl/mtec_pkg.sv @@
// ----------------------------------------------------------------------------
// mtec_pkg
// Shared widths, defaults and the controller-to-datapath command bundle of
// the move-to-end list cipher.
// ----------------------------------------------------------------------------
package mtec_pkg;

   localparam int SYMBOL_W           = 8;
   localparam int LIST_DEPTH_DEFAULT = 256;

   typedef struct packed {
      logic capture;   // take an input transaction, run the list compare
      logic commit;    // reorder the list and load the result register
   } cmd_type;

endpackage

@@ rtl/mtec_controller.sv @@
// ----------------------------------------------------------------------------
// mtec_controller
// Two-state sequencer: accept a transaction, then commit the list update
// once the result register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
module mtec_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtec_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/mtec_datapath.sv @@
// ----------------------------------------------------------------------------
// mtec_datapath
// Row of list cells with a parallel compare on capture and a
// shift-and-append on commit; holds the mode register and the result.
// ----------------------------------------------------------------------------
module mtec_datapath #(
   parameter int LIST_DEPTH = mtec_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mtec_pkg::cmd_type             cmd,
   input  logic [mtec_pkg::SYMBOL_W-1:0] req_in_symbol,
   input  logic                          req_start_of_message,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   output logic [mtec_pkg::SYMBOL_W-1:0] rsp_out_symbol
);

   localparam int SW    = mtec_pkg::SYMBOL_W;
   localparam int LEN_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = $clog2(LIST_DEPTH);

   logic [SW-1:0]         cell_ff [LIST_DEPTH];
   logic [SW-1:0]         cell_in [LIST_DEPTH];
   logic [LEN_W-1:0]      length_ff, length_in;
   logic                  decrypt_ff;
   logic [SW-1:0]         sym_ff;
   logic [LIST_DEPTH-1:0] match_ff, match_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  found_ff;
   logic [SW-1:0]         out_ff, out_in;

   logic [LEN_W-1:0]      len_eff;
   logic [LIST_DEPTH-1:0] last_vec;
   logic [LIST_DEPTH-1:0] sel_vec;
   logic                  hit_last;
   logic [SW-1:0]         nb_sym;
   logic [SW-1:0]         res_sym;
   logic [SW-1:0]         held_sym;
   logic [IDX_W-1:0]      move_pos;

   // compare every cell against the incoming byte
   always_comb begin
      len_eff = req_start_of_message ? '0 : length_ff;
      pos_in  = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         match_in[k] = (LEN_W'(k) < len_eff) && (cell_ff[k] == req_in_symbol);
         if (match_in[k]) begin
            pos_in = pos_in | IDX_W'(k);
         end
      end
   end

   // neighbour select and move position
   always_comb begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
         last_vec[k] = (LEN_W'(k + 1) == length_ff);
      end
      hit_last = |(match_ff & last_vec);
      if (decrypt_ff) begin
         sel_vec    = (match_ff & ~last_vec) << 1;
         sel_vec[0] = sel_vec[0] | hit_last;
         move_pos   = hit_last ? '0 : IDX_W'(pos_ff + 1'b1);
      end else begin
         sel_vec  = (match_ff >> 1) | (last_vec & {LIST_DEPTH{match_ff[0]}});
         move_pos = pos_ff;
      end
      nb_sym = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         nb_sym = nb_sym | (cell_ff[k] & {SW{sel_vec[k]}});
      end
      res_sym  = found_ff ? nb_sym : sym_ff;
      held_sym = decrypt_ff ? res_sym : sym_ff;
      out_in   = cmd.commit ? res_sym : out_ff;
   end

   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [SW-1:0] up_sym;
      logic          shift_en;
      if (k < LIST_DEPTH - 1) begin : g_up
         assign up_sym = cell_ff[k + 1];
      end else begin : g_top
         assign up_sym = held_sym;
      end
      assign shift_en = (IDX_W'(k) >= move_pos) && (LEN_W'(k + 1) < length_ff);
      assign cell_in[k] =
         !cmd.commit                                ? cell_ff[k] :
         (found_ff && last_vec[k])                  ? held_sym   :
         (found_ff && shift_en)                     ? up_sym     :
         (!found_ff && (LEN_W'(k) == length_ff))    ? sym_ff     :
                                                      cell_ff[k];
   end

   always_comb begin
      length_in = length_ff;
      if (cmd.capture && req_start_of_message) begin
         length_in = '0;
      end else if (cmd.commit && !found_ff && (length_ff < LEN_W'(LIST_DEPTH))) begin
         length_in = length_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         if (csr_wr_en) begin
            decrypt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
         cell_ff[k] <= cell_in[k];
      end
      out_ff <= out_in;
      if (cmd.capture) begin
         sym_ff   <= req_in_symbol;
         match_ff <= match_in;
         pos_ff   <= pos_in;
         found_ff <= |match_in;
      end
   end

   assign rsp_out_symbol = out_ff;

endmodule

@@ rtl/move_to_end_list_cipher_top.sv @@
// ----------------------------------------------------------------------------
// move_to_end_list_cipher_top
// Move-to-end list cipher: substitutes each listed byte by its list neighbour,
// passes new bytes through and reorders the list of distinct message bytes.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_in_symbol, req_start_of_message
//   rsp     | out       | rsp_valid, rsp_stall, rsp_out_symbol
//   csr     | in        | csr_wr_en, csr_wr_data (decrypt_mode)
//
// Each transaction has an accept cycle, which compares all list cells in
// parallel, and a commit cycle, which shifts the list and loads the result
// register. A new transaction is accepted in the cycle after the commit.
// Reset clears the list length and the mode; cell contents need no clearing.
// While the result register is held by rsp_stall, the commit cycle waits.
// ----------------------------------------------------------------------------
module move_to_end_list_cipher_top #(
   parameter int LIST_DEPTH = mtec_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mtec_pkg::SYMBOL_W-1:0] req_in_symbol,
   input  logic                          req_start_of_message,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mtec_pkg::SYMBOL_W-1:0] rsp_out_symbol,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);

   mtec_pkg::cmd_type cmd;

   mtec_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mtec_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_in_symbol        (req_in_symbol),
      .req_start_of_message (req_start_of_message),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .rsp_out_symbol       (rsp_out_symbol)
   );

endmodule

@@ rtl/mtec_checker.sv @@
// ----------------------------------------------------------------------------
// mtec_checker
// Port-level checks of the cipher top level, attached by bind.
// ----------------------------------------------------------------------------
module mtec_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [mtec_pkg::SYMBOL_W-1:0] req_in_symbol,
   input logic                          req_start_of_message,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mtec_pkg::SYMBOL_W-1:0] rsp_out_symbol
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_symbol))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken during update");

   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a transaction in progress");

   a_fresh_message_passes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_start_of_message && !rsp_valid
      |-> ##2 (rsp_valid && (rsp_out_symbol == $past(req_in_symbol, 2))))
      else $error("first byte of a message not passed through");

endmodule

bind move_to_end_list_cipher_top mtec_checker u_mtec_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_in_symbol        (req_in_symbol),
   .req_start_of_message (req_start_of_message),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_symbol       (rsp_out_symbol)
);

@@ tb/move_to_end_list_cipher_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_end_list_cipher_top_tb
// Self-checking bench for the move-to-end list cipher. A behavioural model of
// the symbol list predicts each output byte as its transaction is accepted.
// Results are compared in order while both channels idle and stall at random.
// Covers directed corner cases, a message that fills the list with all 256
// byte values, and random messages in both modes.
// ----------------------------------------------------------------------------
module move_to_end_list_cipher_top_tb;

   localparam int LIST_DEPTH    = mtec_pkg::LIST_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 20;

   typedef logic [mtec_pkg::SYMBOL_W-1:0] symbol_type;
   typedef enum logic {MODE_ENCRYPT = 1'b0, MODE_DECRYPT = 1'b1} cipher_mode_type;

   logic       clock                = 1'b0;
   logic       reset                = 1'b1;
   logic       req_valid            = 1'b0;
   logic       req_stall;
   symbol_type req_in_symbol        = '0;
   logic       req_start_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall            = 1'b0;
   symbol_type rsp_out_symbol;
   logic       csr_wr_en            = 1'b0;
   logic       csr_wr_data          = 1'b0;

   symbol_type      symbol_order[$];
   symbol_type      expected_out_q[$];
   symbol_type      expected_symbol;
   cipher_mode_type cipher_mode   = MODE_ENCRYPT;
   int              error_count   = 0;
   int              send_gap_pct  = 0;
   int              stall_pct     = 0;
   int              stall_left    = 0;
   int              idle_cycles   = 0;

   always #1 clock = ~clock;

   move_to_end_list_cipher_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_symbol       (req_in_symbol),
      .req_start_of_message(req_start_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_symbol      (rsp_out_symbol),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   function automatic int draw_gap_length();
      if ($urandom_range(9) == 0) begin
         return $urandom_range(12, 48);
      end
      return $urandom_range(1, 3);
   endfunction

   // neighbour substitution and list reorder for one byte
   function automatic symbol_type transform_symbol(input symbol_type sym,
                                                   input logic new_msg);
      int         pos;
      int         nb;
      int         moved;
      symbol_type res;
      symbol_type held;
      if (new_msg) begin
         symbol_order.delete();
      end
      pos = -1;
      foreach (symbol_order[k]) begin
         if (pos < 0 && symbol_order[k] == sym) begin
            pos = k;
         end
      end
      if (pos < 0) begin
         if (symbol_order.size() < LIST_DEPTH) begin
            symbol_order.push_back(sym);
         end
         return sym;
      end
      if (cipher_mode == MODE_ENCRYPT) begin
         nb    = (pos == 0) ? symbol_order.size() - 1 : pos - 1;
         moved = pos;
      end else begin
         nb    = (pos == symbol_order.size() - 1) ? 0 : pos + 1;
         moved = nb;
      end
      res  = symbol_order[nb];
      held = symbol_order[moved];
      symbol_order.delete(moved);
      symbol_order.push_back(held);
      return res;
   endfunction

   task automatic send_symbol(input symbol_type sym, input logic new_msg);
      req_valid            <= 1'b1;
      req_in_symbol        <= sym;
      req_start_of_message <= new_msg;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_out_q.push_back(transform_symbol(sym, new_msg));
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat (draw_gap_length()) @(posedge clock);
      end
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_out_q.size() != 0);
   endtask

   task automatic set_mode(input cipher_mode_type mode);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cipher_mode = mode;
   endtask

   task automatic run_random_messages(input cipher_mode_type mode, input int item_total);
      int         sent;
      int         msg_len;
      int         alphabet;
      int         k;
      symbol_type base;
      logic       new_msg;
      set_mode(mode);
      sent = 0;
      while (sent < item_total) begin
         msg_len  = ($urandom_range(7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 30);
         alphabet = ($urandom_range(5) == 0) ? 256 : $urandom_range(1, 12);
         base     = symbol_type'($urandom);
         case ($urandom_range(2))
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 15;
               stall_pct    = 15;
            end
            default: begin
               send_gap_pct = 50;
               stall_pct    = 50;
            end
         endcase
         if ($urandom_range(9) == 0) begin
            drain_results();
         end
         for (k = 0; k < msg_len; k++) begin
            new_msg = (k == 0) ? ($urandom_range(15) != 0) : ($urandom_range(63) == 0);
            send_symbol(symbol_type'(base + $urandom_range(alphabet - 1)), new_msg);
            sent++;
         end
      end
   endtask

   task automatic test_directed;
      send_gap_pct = 30;
      stall_pct    = 30;
      set_mode(MODE_ENCRYPT);
      send_symbol(8'h00, 1'b1);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h5A, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h5A, 1'b1);
      send_symbol(8'hA5, 1'b0);
      send_symbol(8'h5A, 1'b0);
      set_mode(MODE_DECRYPT);
      send_symbol(8'h00, 1'b1);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h80, 1'b0);
      send_symbol(8'h80, 1'b0);
      send_symbol(8'h01, 1'b0);
      send_symbol(8'h80, 1'b0);
      send_symbol(8'h7F, 1'b0);
      send_symbol(8'h7F, 1'b0);
      send_symbol(8'hFF, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'hFE, 1'b0);
      send_symbol(8'hFF, 1'b0);
   endtask

   task automatic test_full_alphabet;
      symbol_type perm[LIST_DEPTH];
      symbol_type tmp;
      int         j;
      int         k;
      set_mode(MODE_ENCRYPT);
      send_gap_pct = 0;
      stall_pct    = 0;
      for (k = 0; k < LIST_DEPTH; k++) begin
         perm[k] = symbol_type'(k);
      end
      for (k = LIST_DEPTH - 1; k > 0; k--) begin
         j       = $urandom_range(k);
         tmp     = perm[k];
         perm[k] = perm[j];
         perm[j] = tmp;
      end
      for (k = 0; k < LIST_DEPTH; k++) begin
         send_symbol(perm[k], k == 0);
      end
      for (k = 0; k < 64; k++) begin
         send_symbol(symbol_type'($urandom), 1'b0);
      end
   endtask

   task automatic test_encrypt_random;
      run_random_messages(MODE_ENCRYPT, 400);
   endtask

   task automatic test_decrypt_random;
      run_random_messages(MODE_DECRYPT, 400);
   endtask

   task automatic test_mode_toggling;
      int k;
      for (k = 0; k < 4; k++) begin
         run_random_messages((k % 2 == 0) ? MODE_DECRYPT : MODE_ENCRYPT, 90);
      end
   endtask

   // check each accepted result and drive random stall on the result channel
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out_q.size() == 0) begin
            if (error_count < 10) begin
               $display("unexpected transaction: out_symbol %h", rsp_out_symbol);
            end
            error_count++;
         end else begin
            expected_symbol = expected_out_q.pop_front();
            if (rsp_out_symbol !== expected_symbol) begin
               if (error_count < 10) begin
                  $display("out_symbol mismatch: expected %h, actual %h",
                           expected_symbol, rsp_out_symbol);
               end
               error_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
         stall_left = draw_gap_length();
      end
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[move_to_end_list_cipher_top] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_alphabet();
      test_encrypt_random();
      test_decrypt_random();
      test_mode_toggling();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[move_to_end_list_cipher_top] OK");
      end else begin
         $display("[move_to_end_list_cipher_top] ERROR");
      end
      $finish;
   end

endmodule
